[src/cic_particle_deposit_macros.svh]
// Assertion macros shared by the particle deposition block
`ifndef CIC_PARTICLE_DEPOSIT_MACROS_SVH
`define CIC_PARTICLE_DEPOSIT_MACROS_SVH

// Condition now implies consequence in the same cycle
`define CPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition now implies consequence in the next cycle
`define CPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cpd_pkg.sv]
// Shared types, codes and constants of the particle deposition block
package cpd_pkg;

    localparam int AXIS_CELLS_MAX_DEF = 16;
    localparam int WEIGHT_WIDTH_DEF   = 32;
    localparam int Q_ONE              = 65536;
    localparam int CFG_IDX_W          = 3;
    localparam int SIZE_W             = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SWEEP,
        OP_CAPTURE,
        OP_SIZE,
        OP_MUL,
        OP_MAP,
        OP_CORNER,
        OP_DEP_READ,
        OP_DEP_WRITE,
        OP_CELL_READ,
        OP_CELL_CLEAR,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] axis;
        logic [2:0] corner;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic outside;
        logic corner_ok;
        logic sweep_done;
    } stat_t;

    function automatic int eff_size(input logic [SIZE_W-1:0] s, input int amax);
        int v;
        v = int'(s);
        if (v == 0)
        begin
            return 1;
        end
        if (v > amax)
        begin
            return amax;
        end
        return v;
    endfunction

endpackage

[src/cpd_ctrl.sv]
// Sequencer of the particle deposition block
`include "cic_particle_deposit_macros.svh"

module cpd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output cpd_pkg::cmd_t  cmd,
    input  cpd_pkg::stat_t stat
);

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_SIZE,
        S_MUL,
        S_MAP,
        S_CHECK,
        S_CORNER,
        S_DEP_RD,
        S_DEP_WR,
        S_CELL_RD,
        S_CELL_WR,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [2:0] corner_reg, corner_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        corner_next = corner_reg;
        done_next   = 1'b0;
        cmd.op      = cpd_pkg::OP_NONE;
        cmd.axis    = axis_reg;
        cmd.corner  = corner_reg;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.op = cpd_pkg::OP_SWEEP;
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = cpd_pkg::OP_CAPTURE;
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                cmd.op    = cpd_pkg::OP_SIZE;
                axis_next = 2'd0;
                state_next = stat.is_read ? S_CELL_RD : S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = cpd_pkg::OP_MUL;
                state_next = S_MAP;
            end
            S_MAP:
            begin
                cmd.op = cpd_pkg::OP_MAP;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_CHECK:
            begin
                corner_next = 3'd0;
                state_next  = stat.outside ? S_FIN : S_CORNER;
            end
            S_CORNER:
            begin
                cmd.op = cpd_pkg::OP_CORNER;
                if (stat.corner_ok)
                begin
                    state_next = S_DEP_RD;
                end
                else if (corner_reg == 3'd7)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    corner_next = corner_reg + 3'd1;
                end
            end
            S_DEP_RD:
            begin
                cmd.op     = cpd_pkg::OP_DEP_READ;
                state_next = S_DEP_WR;
            end
            S_DEP_WR:
            begin
                cmd.op = cpd_pkg::OP_DEP_WRITE;
                if (corner_reg == 3'd7)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = S_CORNER;
                end
            end
            S_CELL_RD:
            begin
                cmd.op     = cpd_pkg::OP_CELL_READ;
                state_next = S_CELL_WR;
            end
            S_CELL_WR:
            begin
                cmd.op     = cpd_pkg::OP_CELL_CLEAR;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = cpd_pkg::OP_FINISH;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            axis_reg   <= 2'd0;
            corner_reg <= 3'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            corner_reg <= corner_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `CPD_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe longer than one cycle")
    `CPD_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result strobe while busy")
    `CPD_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `CPD_ASSERT_SAME(a_sweep_busy, clk, rst_n, state_reg == S_SWEEP, busy, "idle during clearing pass")

endmodule

[src/cpd_datapath.sv]
// Axis mapping, corner weights and grid store of the particle deposition block
module cpd_datapath #(
    parameter int AXIS_CELLS_MAX = cpd_pkg::AXIS_CELLS_MAX_DEF,
    parameter int WEIGHT_WIDTH   = cpd_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cpd_pkg::SIZE_W-1:0]  size_x,
    input  logic [cpd_pkg::SIZE_W-1:0]  size_y,
    input  logic [cpd_pkg::SIZE_W-1:0]  size_z,
    input  logic [31:0]                 scale_x,
    input  logic [31:0]                 scale_y,
    input  logic [31:0]                 scale_z,
    input  logic                        mode,
    input  logic signed [31:0]          pos_x,
    input  logic signed [31:0]          pos_y,
    input  logic signed [31:0]          pos_z,
    input  logic                        is_neutron,
    input  logic [12:0]                 cell_index,
    input  cpd_pkg::cmd_t               cmd,
    output cpd_pkg::stat_t              stat,
    output logic [31:0]                 cell_weight,
    output logic [1:0]                  status
);

    localparam int DEPTH = 2 * AXIS_CELLS_MAX * AXIS_CELLS_MAX * AXIS_CELLS_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(AXIS_CELLS_MAX + 1);
    localparam int CW    = $clog2(AXIS_CELLS_MAX);
    localparam int NYZW  = $clog2(AXIS_CELLS_MAX * AXIS_CELLS_MAX + 1);
    localparam int CELLW = $clog2(AXIS_CELLS_MAX * AXIS_CELLS_MAX * AXIS_CELLS_MAX + 1);
    localparam int IDXW  = (CELLW + 2 > 14) ? CELLW + 2 : 14;
    localparam int W     = WEIGHT_WIDTH;

    logic [W-1:0] mem [DEPTH];

    logic [NW-1:0]  nx, ny, nz, n_sel;
    logic [31:0]    scale_sel, pos_sel, mag;

    logic           mode_reg, neut_reg;
    logic [31:0]    pos_reg [3];
    logic [12:0]    idx_reg;
    logic [NYZW-1:0]  nyz_reg;
    logic [CELLW-1:0] cells_reg;
    logic [63:0]    prod_reg;
    logic           neg_reg;
    logic [CW-1:0]  cell_reg [3];
    logic [15:0]    frac_reg [3];
    logic [32:0]    wxy_reg;
    logic [16:0]    wz_reg;
    logic [16:0]    w_reg;
    logic [AW-1:0]  addr_reg;
    logic [W-1:0]   rdata_reg;
    logic [31:0]    weight_reg;
    logic [1:0]     status_reg;

    logic           outside_reg, sat_reg, bad_reg;
    logic [AW-1:0]  sweep_reg;

    logic [48:0]    q, half, c;
    logic [32:0]    cell_wide;
    logic           map_ok;

    logic [CW:0]    cx, cy, cz;
    logic           corner_ok;
    logic [16:0]    wx, wy, wz;
    logic [AW:0]    corner_addr;
    logic [49:0]    wprod;
    logic [W:0]     sum;
    logic           sum_sat;
    logic           idx_bad;
    logic [AW-1:0]  idx_addr;
    logic [63:0]    rd_ext;

    assign nx = NW'(cpd_pkg::eff_size(size_x, AXIS_CELLS_MAX));
    assign ny = NW'(cpd_pkg::eff_size(size_y, AXIS_CELLS_MAX));
    assign nz = NW'(cpd_pkg::eff_size(size_z, AXIS_CELLS_MAX));

    always_comb
    begin
        case (cmd.axis)
            2'd0:
            begin
                n_sel = nx; scale_sel = scale_x; pos_sel = pos_reg[0];
            end
            2'd1:
            begin
                n_sel = ny; scale_sel = scale_y; pos_sel = pos_reg[1];
            end
            default:
            begin
                n_sel = nz; scale_sel = scale_z; pos_sel = pos_reg[2];
            end
        endcase
    end

    assign mag = pos_sel[31] ? (~pos_sel + 32'd1) : pos_sel;

    // Floor of the signed coordinate: round the magnitude up for negative positions
    always_comb
    begin
        q         = {1'b0, prod_reg[63:16]} + 49'(|prod_reg[15:0]);
        half      = 49'(n_sel) << 15;
        map_ok    = 1'b1;
        if (neg_reg)
        begin
            map_ok = (q <= half);
            c      = half - q;
        end
        else
        begin
            c = half + {1'b0, prod_reg[63:16]};
        end
        cell_wide = c[48:16];
        map_ok    = map_ok && (cell_wide < 33'(n_sel));
    end

    always_comb
    begin
        cx = (CW+1)'(cell_reg[0]) + (CW+1)'(cmd.corner[0]);
        cy = (CW+1)'(cell_reg[1]) + (CW+1)'(cmd.corner[1]);
        cz = (CW+1)'(cell_reg[2]) + (CW+1)'(cmd.corner[2]);
        corner_ok = ((NW+1)'(cx) < (NW+1)'(nx)) && ((NW+1)'(cy) < (NW+1)'(ny))
                  && ((NW+1)'(cz) < (NW+1)'(nz));
        wx = cmd.corner[0] ? {1'b0, frac_reg[0]} : 17'(cpd_pkg::Q_ONE) - {1'b0, frac_reg[0]};
        wy = cmd.corner[1] ? {1'b0, frac_reg[1]} : 17'(cpd_pkg::Q_ONE) - {1'b0, frac_reg[1]};
        wz = cmd.corner[2] ? {1'b0, frac_reg[2]} : 17'(cpd_pkg::Q_ONE) - {1'b0, frac_reg[2]};
        corner_addr = (neut_reg ? (AW+1)'(cells_reg) : '0)
                    + (AW+1)'(cx) * (AW+1)'(nyz_reg)
                    + (AW+1)'(cy) * (AW+1)'(nz)
                    + (AW+1)'(cz);
    end

    assign wprod   = 50'(wxy_reg) * 50'(wz_reg);
    assign sum     = (W+1)'(rdata_reg) + (W+1)'(w_reg);
    assign sum_sat = sum[W];
    assign idx_bad = (IDXW'(idx_reg) >= (IDXW'(cells_reg) << 1));
    assign idx_addr = AW'(idx_reg);
    assign rd_ext  = 64'(rdata_reg);

    // Grid store: one port, read registered
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cpd_pkg::OP_SWEEP:      mem[sweep_reg] <= '0;
            cpd_pkg::OP_DEP_READ:   rdata_reg <= mem[addr_reg];
            cpd_pkg::OP_DEP_WRITE:  mem[addr_reg] <= sum_sat ? '1 : sum[W-1:0];
            cpd_pkg::OP_CELL_READ:  rdata_reg <= mem[idx_addr];
            cpd_pkg::OP_CELL_CLEAR:
            begin
                if (!bad_reg)
                begin
                    mem[addr_reg] <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cpd_pkg::OP_CAPTURE:
            begin
                mode_reg   <= mode;
                neut_reg   <= is_neutron;
                pos_reg[0] <= pos_x;
                pos_reg[1] <= pos_y;
                pos_reg[2] <= pos_z;
                idx_reg    <= cell_index;
                nyz_reg    <= NYZW'(ny * nz);
            end
            cpd_pkg::OP_SIZE:
            begin
                cells_reg <= CELLW'(CELLW'(nx) * CELLW'(nyz_reg));
            end
            cpd_pkg::OP_MUL:
            begin
                prod_reg <= 64'(scale_sel) * 64'(mag);
                neg_reg  <= pos_sel[31];
            end
            cpd_pkg::OP_MAP:
            begin
                cell_reg[cmd.axis] <= c[16+CW-1:16];
                frac_reg[cmd.axis] <= c[15:0];
            end
            cpd_pkg::OP_CORNER:
            begin
                wxy_reg  <= 33'(wx) * 33'(wy);
                wz_reg   <= wz;
                addr_reg <= corner_addr[AW-1:0];
            end
            cpd_pkg::OP_DEP_READ:
            begin
                w_reg <= wprod[48:32];
            end
            cpd_pkg::OP_CELL_READ:
            begin
                addr_reg <= idx_addr;
            end
            cpd_pkg::OP_FINISH:
            begin
                weight_reg <= 32'd0;
                if (mode_reg && !bad_reg)
                begin
                    weight_reg <= (rd_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd_ext[31:0];
                end
                if (mode_reg)
                begin
                    status_reg <= bad_reg ? cpd_pkg::ST_BAD_ADDR : cpd_pkg::ST_OK;
                end
                else if (outside_reg)
                begin
                    status_reg <= cpd_pkg::ST_OUTSIDE;
                end
                else
                begin
                    status_reg <= sat_reg ? cpd_pkg::ST_SAT : cpd_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Flags and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg <= 1'b0;
            sat_reg     <= 1'b0;
            bad_reg     <= 1'b0;
            sweep_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                cpd_pkg::OP_SWEEP:
                begin
                    sweep_reg <= sweep_reg + AW'(1);
                end
                cpd_pkg::OP_CAPTURE:
                begin
                    outside_reg <= 1'b0;
                    sat_reg     <= 1'b0;
                    bad_reg     <= 1'b0;
                end
                cpd_pkg::OP_MAP:
                begin
                    outside_reg <= outside_reg | !map_ok;
                end
                cpd_pkg::OP_DEP_WRITE:
                begin
                    sat_reg <= sat_reg | sum_sat;
                end
                cpd_pkg::OP_CELL_READ:
                begin
                    bad_reg <= idx_bad;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.is_read    = mode_reg;
    assign stat.outside    = outside_reg;
    assign stat.corner_ok  = corner_ok;
    assign stat.sweep_done = (sweep_reg == AW'(DEPTH - 1));

    assign cell_weight = weight_reg;
    assign status      = status_reg;

endmodule

[src/cic_particle_deposit.sv]
// Top level of the cloud-in-cell particle deposition block
//
// After reset the block clears all 2*AXIS_CELLS_MAX^3 cells of its grid store
// (8192 at the defaults), one cell a cycle, with busy high; the configuration
// port takes writes throughout. An item is taken when start is high and busy
// low. A read-and-clear item reads and then clears its cell before the done
// strobe; a deposit runs the three axis multiplies, the bounds check, then,
// unless it is off the grid, a check for each corner and, for each corner on
// the grid, a read, add and write on the single-ported store, and the finish.
// The result appears on cell_weight and status with done, which is high for one
// cycle, and holds until the next finish; the receiver cannot hold it off.
module cic_particle_deposit #(
    parameter int AXIS_CELLS_MAX = cpd_pkg::AXIS_CELLS_MAX_DEF,
    parameter int WEIGHT_WIDTH   = cpd_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          mode,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic                          is_neutron,
    input  logic [12:0]                   cell_index,
    output logic [31:0]                   cell_weight,
    output logic [1:0]                    status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    logic [cpd_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [31:0]                scale_x_reg, scale_y_reg, scale_z_reg;
    cpd_pkg::cmd_t              cmd;
    cpd_pkg::stat_t             stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg  <= 5'd16;
            size_y_reg  <= 5'd16;
            size_z_reg  <= 5'd16;
            scale_x_reg <= 32'(cpd_pkg::Q_ONE);
            scale_y_reg <= 32'(cpd_pkg::Q_ONE);
            scale_z_reg <= 32'(cpd_pkg::Q_ONE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cpd_pkg::CFG_SIZE_X:  size_x_reg  <= cfg_data[cpd_pkg::SIZE_W-1:0];
                cpd_pkg::CFG_SIZE_Y:  size_y_reg  <= cfg_data[cpd_pkg::SIZE_W-1:0];
                cpd_pkg::CFG_SIZE_Z:  size_z_reg  <= cfg_data[cpd_pkg::SIZE_W-1:0];
                cpd_pkg::CFG_SCALE_X: scale_x_reg <= cfg_data;
                cpd_pkg::CFG_SCALE_Y: scale_y_reg <= cfg_data;
                cpd_pkg::CFG_SCALE_Z: scale_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cpd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    cpd_datapath #(
        .AXIS_CELLS_MAX (AXIS_CELLS_MAX),
        .WEIGHT_WIDTH   (WEIGHT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .size_x      (size_x_reg),
        .size_y      (size_y_reg),
        .size_z      (size_z_reg),
        .scale_x     (scale_x_reg),
        .scale_y     (scale_y_reg),
        .scale_z     (scale_z_reg),
        .mode        (mode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .is_neutron  (is_neutron),
        .cell_index  (cell_index),
        .cmd         (cmd),
        .stat        (stat),
        .cell_weight (cell_weight),
        .status      (status)
    );

endmodule

[tb/sv/cpd_checker.sv]
// Scoreboard for the particle deposition block: grid predictor and result compare
`timescale 1ns / 1ps

module cpd_checker
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic        mode,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic        is_neutron,
    input  logic [12:0] cell_index,
    input  logic [31:0] cell_weight,
    input  logic [1:0]  status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    localparam logic MODE_READ = 1'b1;
    localparam int   GRID_DEPTH = 2 * AXIS_CELLS_MAX_DEF ** 3;

    typedef struct packed {
        logic [31:0] weight;
        logic [1:0]  code;
    } cell_result_t;

    logic [31:0]  grid_acc [0:GRID_DEPTH-1];
    logic [4:0]   span_reg [0:2];
    logic [31:0]  scale_reg [0:2];
    cell_result_t awaited_results [$];

    function automatic int cells_on_axis(input logic [4:0] s);
        if (s == 5'd0)
        begin
            return 1;
        end
        return (int'(s) > AXIS_CELLS_MAX_DEF) ? AXIS_CELLS_MAX_DEF : int'(s);
    endfunction

    // Map one axis to a base cell and Q0.16 fraction; false when off the grid
    function automatic bit place_on_axis(input logic [31:0] p, input logic [31:0] sc,
                                         input int n, output int cell_no,
                                         output logic [15:0] frac);
        logic [63:0] mag, prod, half, q, c;
        mag  = p[31] ? {32'd0, (~p + 32'd1)} : {32'd0, p};
        prod = {32'd0, sc} * mag;
        half = 64'(n) << 15;
        cell_no = 0;
        frac = '0;
        if (p[31])
        begin
            q = (prod >> 16) + ((prod[15:0] != 16'd0) ? 64'd1 : 64'd0);
            if (q > half)
            begin
                return 1'b0;
            end
            c = half - q;
        end
        else
        begin
            c = half + (prod >> 16);
        end
        if ((c >> 16) >= 64'(n))
        begin
            return 1'b0;
        end
        cell_no = int'(c >> 16);
        frac = c[15:0];
        return 1'b1;
    endfunction

    task automatic deposit_or_read(output cell_result_t r);
        int nx, ny, nz, cells, cx, cy, cz, x, y, z, addr;
        logic [15:0] fx, fy, fz;
        logic [63:0] wx, wy, wz, w;
        logic [32:0] sum;
        bit on_grid;
        nx = cells_on_axis(span_reg[0]);
        ny = cells_on_axis(span_reg[1]);
        nz = cells_on_axis(span_reg[2]);
        cells = nx * ny * nz;
        r = '{weight: '0, code: ST_OK};
        if (mode == MODE_READ)
        begin
            if (int'(cell_index) >= 2 * cells)
            begin
                r.code = ST_BAD_ADDR;
            end
            else
            begin
                r.weight = grid_acc[cell_index];
                grid_acc[cell_index] = '0;
            end
            return;
        end
        on_grid = place_on_axis(pos_x, scale_reg[0], nx, cx, fx);
        on_grid &= place_on_axis(pos_y, scale_reg[1], ny, cy, fy);
        on_grid &= place_on_axis(pos_z, scale_reg[2], nz, cz, fz);
        if (!on_grid)
        begin
            r.code = ST_OUTSIDE;
            return;
        end
        for (int k = 0; k < 8; k++)
        begin
            x = cx + k[0];
            y = cy + k[1];
            z = cz + k[2];
            // drop corners past the upper edge
            if (x >= nx || y >= ny || z >= nz)
            begin
                continue;
            end
            wx = k[0] ? 64'(fx) : 64'(Q_ONE) - 64'(fx);
            wy = k[1] ? 64'(fy) : 64'(Q_ONE) - 64'(fy);
            wz = k[2] ? 64'(fz) : 64'(Q_ONE) - 64'(fz);
            w = (wx * wy * wz) >> 32;
            addr = (is_neutron ? cells : 0) + x * ny * nz + y * nz + z;
            sum = {1'b0, grid_acc[addr]} + w[32:0];
            if (sum[32])
            begin
                sum = {1'b0, 32'hFFFF_FFFF};
                r.code = ST_SAT;
            end
            grid_acc[addr] = sum[31:0];
        end
    endtask

    initial
    begin
        for (int i = 0; i < GRID_DEPTH; i++)
        begin
            grid_acc[i] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t fresh, oldest;
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                span_reg[a]  = 5'd16;
                scale_reg[a] = 32'(Q_ONE);
            end
            fail_count = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result beat with nothing awaited: w=%h st=%0d",
                                 $time, cell_weight, status);
                    end
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    checked++;
                    if (oldest.weight !== cell_weight || oldest.code !== status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch: weight exp %h got %h, status exp %0d got %0d",
                                     $time, oldest.weight, cell_weight, oldest.code, status);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                deposit_or_read(fresh);
                awaited_results.push_back(fresh);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SIZE_X:  span_reg[0]  = cfg_data[4:0];
                    CFG_SIZE_Y:  span_reg[1]  = cfg_data[4:0];
                    CFG_SIZE_Z:  span_reg[2]  = cfg_data[4:0];
                    CFG_SCALE_X: scale_reg[0] = cfg_data;
                    CFG_SCALE_Y: scale_reg[1] = cfg_data;
                    CFG_SCALE_Z: scale_reg[2] = cfg_data;
                    default: ;
                endcase
            end
            pending = awaited_results.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// Top of the particle deposition testbench: stimulus, configuration phases and verdict
`timescale 1ns / 1ps

module testbench;
    import cpd_pkg::*;

    localparam logic MODE_DEPOSIT = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        mode = MODE_DEPOSIT;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic        is_neutron = 1'b0;
    logic [12:0] cell_index = '0;
    logic        cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        busy, done, cfg_ready;
    logic [31:0] cell_weight;
    logic [1:0]  status;
    int          fail_count, pending, checked;

    int          axis_cells [0:2];
    logic [31:0] axis_scale [0:2];
    int          idle_pct;
    int          phase_pct [0:3] = '{0, 73, 0, 34};

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    cic_particle_deposit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .is_neutron(is_neutron), .cell_index(cell_index),
        .cell_weight(cell_weight), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cpd_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .is_neutron(is_neutron), .cell_index(cell_index),
        .cell_weight(cell_weight), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= CFG_SIZE_Z)
        begin
            axis_cells[idx] = (val[4:0] == 0) ? 1 : ((val[4:0] > 16) ? 16 : int'(val[4:0]));
        end
        else
        begin
            axis_scale[idx - CFG_SCALE_X] = val;
        end
    endtask

    task automatic setup_grid(input logic [4:0] sx, sy, sz, input logic [31:0] kx, ky, kz);
        write_reg(CFG_SIZE_X, 32'(sx));
        write_reg(CFG_SIZE_Y, 32'(sy));
        write_reg(CFG_SIZE_Z, 32'(sz));
        write_reg(CFG_SCALE_X, kx);
        write_reg(CFG_SCALE_Y, ky);
        write_reg(CFG_SCALE_Z, kz);
    endtask

    // Hold the beat until the block takes it, then maybe leave a gap
    task automatic issue(input logic m, input logic [31:0] px, py, pz,
                         input logic sp, input logic [12:0] ci);
        start      <= 1'b1;
        mode       <= m;
        pos_x      <= px;
        pos_y      <= py;
        pos_z      <= pz;
        is_neutron <= sp;
        cell_index <= ci;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
    endtask

    // Position whose mapped coordinate mostly lands near or just beyond the grid
    function automatic logic [31:0] aim_axis(input int a);
        longint target;
        if (axis_scale[a] == 0 || $urandom_range(9) == 0)
        begin
            return $urandom;
        end
        target = longint'($urandom_range(axis_cells[a] * 65536 + 65535)) - 32768
                 - longint'(axis_cells[a]) * 32768;
        return 32'((target * 65536) / longint'(axis_scale[a]));
    endfunction

    task automatic random_beat;
        int   cells;
        logic [12:0] ci;
        cells = axis_cells[0] * axis_cells[1] * axis_cells[2];
        if ($urandom_range(99) < 30)
        begin
            ci = ($urandom_range(6) == 0) ? 13'($urandom) : 13'($urandom_range(2 * cells - 1));
            issue(MODE_READ, $urandom, $urandom, $urandom, 1'($urandom), ci);
        end
        else
        begin
            issue(MODE_DEPOSIT, aim_axis(0), aim_axis(1), aim_axis(2),
                  1'($urandom), 13'($urandom));
        end
    endtask

    initial
    begin
        for (int a = 0; a < 3; a++)
        begin
            axis_cells[a] = 16;
            axis_scale[a] = 32'(Q_ONE);
        end
        idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: centre, edges, extremes and reads under the reset setting
        issue(MODE_DEPOSIT, 32'h0, 32'h0, 32'h0, 1'b0, 13'h0);
        issue(MODE_DEPOSIT, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_4000, 1'b1, 13'h1FFF);
        issue(MODE_DEPOSIT, 32'h0007_C000, 32'h0007_FFFF, 32'h0007_0000, 1'b0, 13'h0);
        issue(MODE_DEPOSIT, 32'hFFF8_0000, 32'hFFF8_0000, 32'hFFF8_0000, 1'b1, 13'h0);
        issue(MODE_DEPOSIT, 32'hFFF7_FFFF, 32'h0, 32'h0, 1'b0, 13'h0);
        issue(MODE_DEPOSIT, 32'h0008_0000, 32'h0, 32'h0, 1'b0, 13'h0);
        issue(MODE_DEPOSIT, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 13'h0);
        issue(MODE_DEPOSIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 13'h0);
        issue(MODE_DEPOSIT, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 13'h0);
        issue(MODE_READ, 32'h0, 32'h0, 32'h0, 1'b0, 13'd2184);
        issue(MODE_READ, 32'h0, 32'h0, 32'h0, 1'b0, 13'd2184);
        issue(MODE_READ, 32'h0, 32'h0, 32'h0, 1'b1, 13'd6280);
        issue(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 13'h1FFF);
        issue(MODE_READ, 32'h0, 32'h0, 32'h0, 1'b0, 13'h0);
        drain();
        setup_grid(5'd1, 5'd0, 5'd31, 32'hFFFF_FFFF, 32'h0, 32'h0002_0000);
        issue(MODE_DEPOSIT, 32'h0, 32'h1234_5678, 32'h0000_1000, 1'b1, 13'h0);
        issue(MODE_DEPOSIT, 32'h0000_0001, 32'h0, 32'h0, 1'b0, 13'h0);
        issue(MODE_READ, 32'h0, 32'h0, 32'h0, 1'b0, 13'd32);
        issue(MODE_READ, 32'h0, 32'h0, 32'h0, 1'b0, 13'd31);
        issue(MODE_READ, 32'h0, 32'h0, 32'h0, 1'b0, 13'd0);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: setup_grid(5'd16, 5'd16, 5'd16, 32'(Q_ONE), 32'(Q_ONE), 32'(Q_ONE));
                1: setup_grid(5'd4, 5'd3, 5'd5, 32'h0001_0000, 32'h0000_8000,
                              32'h0002_0000);
                2: setup_grid(5'd1, 5'd1, 5'd1, 32'h0002_0000, 32'h0002_0000,
                              32'h0002_0000);
                3: setup_grid(5'd0, 5'd17, 5'd31, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
                4: setup_grid(5'd2, 5'd7, 5'd16, $urandom_range(32'h3_0000, 32'h100),
                              $urandom_range(32'h3_0000, 32'h100), $urandom);
                default: setup_grid(5'd16, 5'd15, 5'd2, 32'h0000_4000, 32'h0001_0000,
                                    32'h0001_8000);
            endcase
            idle_pct = phase_pct[ph % 4];
            repeat (105) random_beat();
        end
        drain();

        $display("Covered %0d results over seven grid settings, sizes 0 to 31,", checked);
        $display("scales 0 to max, both planes, reads, bad addresses and sender gaps.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/cpd_pkg.sv
src/cpd_ctrl.sv
src/cpd_datapath.sv
src/cic_particle_deposit.sv
tb/sv/cpd_checker.sv
tb/sv/testbench.sv
